// File: rtl/nfmt_pkg.sv
// Shared types, constants and lookup functions for the seven-segment number formatter.
`default_nettype none

package nfmt_pkg;

    // Field widths
    localparam int VALUE_W  = 48;
    localparam int FRAC_W   = 3;
    localparam int BASE_W   = 5;
    localparam int POS_W    = 3;
    localparam int SEG_W    = 8;
    localparam int V_W      = 16;   // rounded scaled value, always below 16^4
    localparam int LIM_W    = 17;   // holds 16^4
    localparam int DIGIT_W  = 4;

    // Defaults for top-level parameters
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Display geometry
    localparam int DIGIT_SLOTS = 5;
    localparam logic [POS_W-1:0] POS_TOP    = POS_W'(DIGIT_SLOTS - 1);
    localparam logic [POS_W-1:0] POS_COLON  = 3'd2;
    localparam logic [POS_W-1:0] POS_BOTTOM = 3'd0;

    // Radix limits and reset value
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

    // Divider: quotient bits resolved per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = V_W / DIV_BITS;

    // Fixed segment patterns
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam int DOT_BIT = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]         fraction_digits;
    } nfmt_in_t;

    typedef struct packed {
        logic [POS_W-1:0] digit_position;
        logic [SEG_W-1:0] segments;
        logic             last;
    } nfmt_out_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic              err;
        logic              neg;
        logic [FRAC_W-1:0] k;
        logic [V_W-1:0]    v;
        logic [BASE_W-1:0] base;
    } nfmt_entry_t;

    // Glyph for one digit 0..F
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0:    s = 8'h3F;
            4'h1:    s = 8'h06;
            4'h2:    s = 8'h5B;
            4'h3:    s = 8'h4F;
            4'h4:    s = 8'h66;
            4'h5:    s = 8'h6D;
            4'h6:    s = 8'h7D;
            4'h7:    s = 8'h07;
            4'h8:    s = 8'h7F;
            4'h9:    s = 8'h6F;
            4'hA:    s = 8'h77;
            4'hB:    s = 8'h7C;
            4'hC:    s = 8'h39;
            4'hD:    s = 8'h5E;
            4'hE:    s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    // First value that no longer fits: base^3 when negative, base^4 otherwise
    function automatic logic [LIM_W-1:0] limit_of(input logic [BASE_W-1:0] b,
                                                  input logic neg);
        logic [LIM_W-1:0] c;
        logic [LIM_W-1:0] q;
        case (b)
            5'd2:    begin c = 17'd8;    q = 17'd16;    end
            5'd3:    begin c = 17'd27;   q = 17'd81;    end
            5'd4:    begin c = 17'd64;   q = 17'd256;   end
            5'd5:    begin c = 17'd125;  q = 17'd625;   end
            5'd6:    begin c = 17'd216;  q = 17'd1296;  end
            5'd7:    begin c = 17'd343;  q = 17'd2401;  end
            5'd8:    begin c = 17'd512;  q = 17'd4096;  end
            5'd9:    begin c = 17'd729;  q = 17'd6561;  end
            5'd10:   begin c = 17'd1000; q = 17'd10000; end
            5'd11:   begin c = 17'd1331; q = 17'd14641; end
            5'd12:   begin c = 17'd1728; q = 17'd20736; end
            5'd13:   begin c = 17'd2197; q = 17'd28561; end
            5'd14:   begin c = 17'd2744; q = 17'd38416; end
            5'd15:   begin c = 17'd3375; q = 17'd50625; end
            default: begin c = 17'd4096; q = 17'd65536; end
        endcase
        return neg ? c : q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/number_to_seven_segment_formatter_core.sv
// The front end runs its scale steps, one per digit count tried, at most 8, and pushes the entry
// into the queue; the back end then writes the slots. A digit slot takes the slot check, the radix
// divider and the beat; colon, sign, blank and dash slots are written from the slot check alone.
// The front scales the next value while the back still writes, unless a full queue holds it at
// its push. Every value gives five strobed beats.
// Reset (rst_n low, asynchronous) empties the queue, idles both ends and sets the radix to ten.
`default_nettype none

module number_to_seven_segment_formatter_core #(
    parameter int FRACTION_BITS = nfmt_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = nfmt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  nfmt_pkg::nfmt_in_t          operand,
    output logic                        strobe,
    output nfmt_pkg::nfmt_out_t         slot,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire [nfmt_pkg::BASE_W-1:0]  cfg_data
);

    logic [nfmt_pkg::BASE_W-1:0] base_reg;
    nfmt_pkg::nfmt_entry_t       front_entry;
    nfmt_pkg::nfmt_entry_t       back_entry;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;

    // Radix register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= nfmt_pkg::BASE_RESET;
        else if (cfg_valid && cfg_ready)
            base_reg <= cfg_data;
    end

    nfmt_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operand  (operand),
        .base_cfg (base_reg),
        .busy     (busy),
        .push     (q_push),
        .entry    (front_entry),
        .full     (q_full)
    );

    nfmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (front_entry),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (back_entry),
        .empty   (q_empty)
    );

    nfmt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .entry  (back_entry),
        .empty  (q_empty),
        .pop    (q_pop),
        .strobe (strobe),
        .slot   (slot)
    );

endmodule

`default_nettype wire

// File: rtl/nfmt_front.sv
// Front end: takes a value, scales by base^k one step a cycle and picks the largest k that fits.
`default_nettype none

module nfmt_front #(
    parameter int FRACTION_BITS = nfmt_pkg::FRACTION_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  nfmt_pkg::nfmt_in_t          operand,
    input  wire [nfmt_pkg::BASE_W-1:0]  base_cfg,
    output logic                        busy,
    output logic                        push,
    output nfmt_pkg::nfmt_entry_t       entry,
    input  wire                         full
);

    localparam int VW    = nfmt_pkg::VALUE_W;
    localparam int BW    = nfmt_pkg::BASE_W;
    localparam int KW    = nfmt_pkg::FRAC_W;
    localparam int SUM_W = VW + 1;
    localparam int PRD_W = VW + BW;
    localparam logic [SUM_W-1:0] HALF = (SUM_W'(1) << FRACTION_BITS) >> 1;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SCALE = 3'b010,
        F_PUSH  = 3'b100
    } fstate_t;

    fstate_t                      state_reg, state_next;
    logic [VW-1:0]                p_reg, p_next;
    logic                         big_reg, big_next;
    logic                         neg_reg, neg_next;
    logic [KW-1:0]                kmax_reg, kmax_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [BW-1:0]                base_reg, base_next;
    logic [nfmt_pkg::LIM_W-1:0]   lim_reg, lim_next;
    logic [nfmt_pkg::V_W-1:0]     bestv_reg, bestv_next;
    logic [KW-1:0]                bestk_reg, bestk_next;
    logic                         found_reg, found_next;

    logic [VW-1:0]    raw;
    logic             in_neg;
    logic [BW-1:0]    base_clamp;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] limit;
    logic [SUM_W-1:0] shifted;
    logic [PRD_W-1:0] prod;
    logic             fit;

    // Input magnitude and clamped radix
    assign raw    = operand.value;
    assign in_neg = raw[VW-1];
    always_comb
    begin
        if (base_cfg < nfmt_pkg::BASE_MIN)
            base_clamp = nfmt_pkg::BASE_MIN;
        else if (base_cfg > nfmt_pkg::BASE_MAX)
            base_clamp = nfmt_pkg::BASE_MAX;
        else
            base_clamp = base_cfg;
    end

    // Fit test on the current scaled magnitude, and the next scale step
    assign sum     = {1'b0, p_reg} + HALF;
    assign limit   = SUM_W'(lim_reg) << FRACTION_BITS;
    assign shifted = sum >> FRACTION_BITS;
    assign fit     = !big_reg && (sum < limit);
    assign prod    = PRD_W'(p_reg) * PRD_W'(base_reg);

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        big_next   = big_reg;
        neg_next   = neg_reg;
        kmax_next  = kmax_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        lim_next   = lim_reg;
        bestv_next = bestv_reg;
        bestk_next = bestk_reg;
        found_next = found_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    p_next     = in_neg ? (~raw + VW'(1)) : raw;
                    big_next   = 1'b0;
                    neg_next   = in_neg;
                    kmax_next  = operand.fraction_digits;
                    k_next     = '0;
                    base_next  = base_clamp;
                    lim_next   = nfmt_pkg::limit_of(base_clamp, in_neg);
                    found_next = 1'b0;
                    state_next = F_SCALE;
                end
            end
            F_SCALE:
            begin
                if (fit)
                begin
                    bestv_next = shifted[nfmt_pkg::V_W-1:0];
                    bestk_next = k_reg;
                    found_next = 1'b1;
                end
                // larger k only grows the value, so stop at the first miss
                if (!fit || (k_reg == kmax_reg))
                    state_next = F_PUSH;
                else
                begin
                    p_next   = prod[VW-1:0];
                    big_next = big_reg || (|prod[PRD_W-1:VW]);
                    k_next   = k_reg + KW'(1);
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    assign busy       = (state_reg != F_IDLE);
    assign entry.err  = !found_reg;
    assign entry.neg  = neg_reg;
    assign entry.k    = bestk_reg;
    assign entry.v    = bestv_reg;
    assign entry.base = base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        big_reg   <= big_next;
        neg_reg   <= neg_next;
        kmax_reg  <= kmax_next;
        k_reg     <= k_next;
        base_reg  <= base_next;
        lim_reg   <= lim_next;
        bestv_reg <= bestv_next;
        bestk_reg <= bestk_next;
        found_reg <= found_next;
    end

endmodule

`default_nettype wire

// File: rtl/nfmt_queue.sv
// Short register queue between front and back ends.
`default_nettype none

module nfmt_queue #(
    parameter int DEPTH = nfmt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  nfmt_pkg::nfmt_entry_t  wr_data,
    output logic                   full,
    input  wire                    pop,
    output nfmt_pkg::nfmt_entry_t  rd_data,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    nfmt_pkg::nfmt_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// File: rtl/nfmt_back.sv
// Back end: extracts digits with a shared radix divider and writes one slot per beat.
`default_nettype none

module nfmt_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  nfmt_pkg::nfmt_entry_t  entry,
    input  wire                    empty,
    output logic                   pop,
    output logic                   strobe,
    output nfmt_pkg::nfmt_out_t    slot
);

    localparam int VW  = nfmt_pkg::V_W;
    localparam int BW  = nfmt_pkg::BASE_W;
    localparam int KW  = nfmt_pkg::FRAC_W;
    localparam int PW  = nfmt_pkg::POS_W;
    localparam int DB  = nfmt_pkg::DIV_BITS;
    localparam int CW  = (nfmt_pkg::DIV_CYCLES > 1) ? $clog2(nfmt_pkg::DIV_CYCLES) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(nfmt_pkg::DIV_CYCLES - 1);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_SLOT  = 4'b0010,
        B_DIV   = 4'b0100,
        B_DIGIT = 4'b1000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic                err_reg, err_next;
    logic                minus_reg, minus_next;   // minus sign still to write
    logic                zero_reg, zero_next;
    logic                digits_reg, digits_next; // more digits to write
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       i_reg, i_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [BW-1:0]       base_reg, base_next;
    logic [BW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                strobe_reg, strobe_next;
    nfmt_pkg::nfmt_out_t slot_reg, slot_next;

    logic [VW-1:0]              div_q;
    logic [BW-1:0]              div_r;
    logic                       dot;
    logic [nfmt_pkg::SEG_W-1:0] digit_seg;

    // Restoring division step: DB quotient bits a cycle, shifted into v
    always_comb
    begin
        div_q = v_reg;
        div_r = rem_reg;
        for (int j = 0; j < DB; j++)
        begin
            div_r = {div_r[BW-2:0], div_q[VW-1]};
            div_q = {div_q[VW-2:0], 1'b0};
            if (div_r >= base_reg)
            begin
                div_r    = div_r - base_reg;
                div_q[0] = 1'b1;
            end
        end
    end

    // Digit glyph with the point on the digit k places up
    assign dot       = (k_reg != '0) && (i_reg == k_reg);
    assign digit_seg = nfmt_pkg::seg_of(rem_reg[nfmt_pkg::DIGIT_W-1:0])
                       | ({{(nfmt_pkg::SEG_W-1){1'b0}}, dot} << nfmt_pkg::DOT_BIT);

    // Slot sequencer
    always_comb
    begin
        state_next  = state_reg;
        err_next    = err_reg;
        minus_next  = minus_reg;
        zero_next   = zero_reg;
        digits_next = digits_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        v_next      = v_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        slot_next   = slot_reg;
        pop         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    err_next    = entry.err;
                    minus_next  = entry.neg;
                    zero_next   = (entry.v == '0);
                    digits_next = 1'b1;
                    k_next      = entry.k;
                    i_next      = '0;
                    v_next      = entry.v;
                    base_next   = entry.base;
                    pos_next    = entry.err ? nfmt_pkg::POS_BOTTOM : nfmt_pkg::POS_TOP;
                    state_next  = B_SLOT;
                end
            end
            B_SLOT:
            begin
                if (err_reg)
                begin
                    // dash pattern, written upward
                    strobe_next              = 1'b1;
                    slot_next.digit_position = pos_reg;
                    slot_next.segments       = (pos_reg == nfmt_pkg::POS_COLON) ?
                                               nfmt_pkg::SEG_BLANK : nfmt_pkg::SEG_MINUS;
                    slot_next.last           = (pos_reg == nfmt_pkg::POS_TOP);
                    if (pos_reg == nfmt_pkg::POS_TOP)
                        state_next = B_IDLE;
                    else
                        pos_next = pos_reg + PW'(1);
                end
                else if (pos_reg == nfmt_pkg::POS_COLON)
                begin
                    strobe_next              = 1'b1;
                    slot_next.digit_position = pos_reg;
                    slot_next.segments       = nfmt_pkg::SEG_BLANK;
                    slot_next.last           = 1'b0;
                    pos_next                 = pos_reg - PW'(1);
                end
                else if (digits_reg)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
                else
                begin
                    // minus sign once, then blanks
                    strobe_next              = 1'b1;
                    slot_next.digit_position = pos_reg;
                    slot_next.segments       = minus_reg ? nfmt_pkg::SEG_MINUS
                                                         : nfmt_pkg::SEG_BLANK;
                    slot_next.last           = (pos_reg == nfmt_pkg::POS_BOTTOM);
                    minus_next               = 1'b0;
                    if (pos_reg == nfmt_pkg::POS_BOTTOM)
                        state_next = B_IDLE;
                    else
                        pos_next = pos_reg - PW'(1);
                end
            end
            B_DIV:
            begin
                v_next   = div_q;
                rem_next = div_r;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = B_DIGIT;
            end
            B_DIGIT:
            begin
                strobe_next              = 1'b1;
                slot_next.digit_position = pos_reg;
                slot_next.segments       = digit_seg;
                slot_next.last           = (pos_reg == nfmt_pkg::POS_BOTTOM);
                i_next                   = i_reg + KW'(1);
                // unless the value is zero, keep going while quotient is nonzero or the point is still ahead
                digits_next = !zero_reg &&
                              ((v_reg != '0) || ({1'b0, i_reg} + 4'd1 <= {1'b0, k_reg}));
                if (pos_reg == nfmt_pkg::POS_BOTTOM)
                    state_next = B_IDLE;
                else
                begin
                    pos_next   = pos_reg - PW'(1);
                    state_next = B_SLOT;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    assign strobe = strobe_reg;
    assign slot   = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        minus_reg  <= minus_next;
        zero_reg   <= zero_next;
        digits_reg <= digits_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        v_reg      <= v_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        slot_reg   <= slot_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_number_to_seven_segment_formatter_core.sv
// Self-checking testbench for the seven-segment number formatter core.
`timescale 1ns / 100ps

module tb_number_to_seven_segment_formatter_core;

    localparam int FRAC_BITS = 16;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 29;
    localparam int NUM_PHASES = 12;
    localparam int NUM_DIRECTED = 22;

    // Glyphs 0..F, entry 0 in the low byte
    localparam logic [15:0][7:0] GLYPH = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // Slot orders for typed expectations, first beat in the top bits
    localparam logic [14:0] POS_DOWN = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [14:0] POS_UP   = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
    localparam logic [39:0] SEGS_DASH = 40'h40_40_00_40_40;

    // Radix settings walked by the random phases
    localparam logic [9:0][4:0] RADIX_PLAN = {
        5'd13, 5'd3, 5'd10, 5'd8, 5'd1, 5'd17, 5'd31, 5'd0, 5'd2, 5'd16
    };

    typedef struct packed {
        logic [47:0] value;
        logic [2:0]  digits;
        logic        typed;
        logic [39:0] segs;
        logic [14:0] poss;
    } stim_row_t;

    // Directed stimulus; typed rows carry their expected beats (radix ten)
    stim_row_t stim_tab [NUM_DIRECTED] = '{
        {48'h0000_0000_0000, 3'd0, 1'b1, 40'h3F_00_00_00_00, POS_DOWN},
        {48'h7FFF_FFFF_FFFF, 3'd4, 1'b1, SEGS_DASH,          POS_UP},
        {48'h8000_0000_0000, 3'd0, 1'b1, SEGS_DASH,          POS_UP},
        {48'hFFFF_FFFF_FFFF, 3'd0, 1'b1, 40'h3F_40_00_00_00, POS_DOWN},
        {48'h0000_0001_0000, 3'd0, 1'b1, 40'h06_00_00_00_00, POS_DOWN},
        {48'h0000_270F_0000, 3'd0, 1'b1, 40'h6F_6F_00_6F_6F, POS_DOWN},
        {48'h0000_2710_0000, 3'd0, 1'b1, SEGS_DASH,          POS_UP},
        {48'hFFFF_FC19_0000, 3'd0, 1'b1, 40'h6F_6F_00_6F_40, POS_DOWN},
        {48'hFFFF_FC18_0000, 3'd0, 1'b1, SEGS_DASH,          POS_UP},
        {48'h0000_0000_8000, 3'd0, 1'b0, 40'h0, 15'h0},
        {48'h0000_0000_7FFF, 3'd0, 1'b0, 40'h0, 15'h0},
        {48'h0000_0001_8000, 3'd1, 1'b0, 40'h0, 15'h0},
        {48'h0000_0003_243F, 3'd4, 1'b0, 40'h0, 15'h0},
        {48'h0000_0000_8000, 3'd2, 1'b0, 40'h0, 15'h0},
        {48'h0000_0000_0007, 3'd4, 1'b0, 40'h0, 15'h0},
        {48'hFFFF_FFFF_C000, 3'd2, 1'b0, 40'h0, 15'h0},
        {48'h0000_000C_8000, 3'd7, 1'b0, 40'h0, 15'h0},
        {48'h0000_007B_74BC, 3'd5, 1'b0, 40'h0, 15'h0},
        {48'hFFFF_FFF3_A8F6, 3'd6, 1'b0, 40'h0, 15'h0},
        {48'h0000_270F_E666, 3'd3, 1'b0, 40'h0, 15'h0},
        {48'h7FFF_FFFF_FFFF, 3'd7, 1'b0, 40'h0, 15'h0},
        {48'h0000_0000_FFFF, 3'd0, 1'b0, 40'h0, 15'h0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    nfmt_pkg::nfmt_in_t   operand = '0;
    logic                 strobe;
    nfmt_pkg::nfmt_out_t  slot;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [nfmt_pkg::BASE_W-1:0] cfg_data = nfmt_pkg::BASE_RESET;

    // Expected beats, oldest first, and the radix register as written
    nfmt_pkg::nfmt_out_t  pending_slots [$];
    logic [4:0]  radix_reg = nfmt_pkg::BASE_RESET;
    int          mismatches = 0;
    int          burst_left = 0;

    number_to_seven_segment_formatter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .strobe    (strobe),
        .slot      (slot),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #400000;
        $display("tb_number_to_seven_segment_formatter_core: FAIL");
        $finish;
    end

    function automatic logic [63:0] clamp_radix(input logic [4:0] r);
        if (r < 5'd2)
            return 64'd2;
        if (r > 5'd16)
            return 64'd16;
        return 64'(r);
    endfunction

    function automatic logic [63:0] radix_pow(input logic [63:0] b, input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
            p = p * b;
        return p;
    endfunction

    // Work out the five beats one value gives and queue them
    function automatic void format_value(input nfmt_pkg::nfmt_in_t item);
        logic [47:0] mag48;
        logic [63:0] mag, b, lim, factor, scaled;
        logic        neg, fits;
        int          k, pos, nw, n;
        int          wpos [16];
        logic [7:0]  wseg [16];
        nfmt_pkg::nfmt_out_t beats [5];

        neg = item.value[47];
        mag48 = neg ? (~item.value + 48'd1) : item.value;
        mag = 64'(mag48);
        b = clamp_radix(radix_reg);
        lim = radix_pow(b, neg ? 3 : 4);
        k = int'(item.fraction_digits);
        fits = 1'b0;
        scaled = 64'd0;
        nw = 0;
        n = 0;

        // Lower the digit count until the scaled value fits
        while (k >= 0 && !fits)
        begin
            factor = radix_pow(b, k);
            if (mag <= 64'h7FFF_FFFF_FFFF_FFFF / factor)
            begin
                scaled = (mag * factor + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                fits = scaled < lim;
            end
            if (!fits)
                k--;
        end

        if (!fits)
        begin
            // dash pattern, slot 0 upward
            for (int i = 0; i < 5; i++)
            begin
                wpos[nw] = i;
                wseg[nw] = (i == 2) ? nfmt_pkg::SEG_BLANK : nfmt_pkg::SEG_MINUS;
                nw++;
            end
        end
        else
        begin
            pos = 4;
            if (scaled != 0)
            begin
                for (int i = 0; scaled != 0 || i <= k; i++)
                begin
                    wpos[nw] = pos;
                    wseg[nw] = GLYPH[4'(scaled % b)];
                    wseg[nw][nfmt_pkg::DOT_BIT] = (k != 0 && i == k);
                    nw++;
                    pos--;
                    if (pos == 2)
                    begin
                        wpos[nw] = pos;
                        wseg[nw] = nfmt_pkg::SEG_BLANK;
                        nw++;
                        pos--;
                    end
                    scaled = scaled / b;
                end
            end
            else
            begin
                wpos[nw] = pos;
                wseg[nw] = GLYPH[0];
                nw++;
                pos--;
            end
            if (neg)
            begin
                wpos[nw] = pos;
                wseg[nw] = nfmt_pkg::SEG_MINUS;
                nw++;
                pos--;
            end
            while (pos >= 0)
            begin
                wpos[nw] = pos;
                wseg[nw] = nfmt_pkg::SEG_BLANK;
                nw++;
                pos--;
            end
        end

        // Writes off the display are dropped
        for (int i = 0; i < nw; i++)
        begin
            if (wpos[i] >= 0 && wpos[i] < nfmt_pkg::DIGIT_SLOTS
                && n < nfmt_pkg::DIGIT_SLOTS)
            begin
                beats[n].digit_position = 3'(wpos[i]);
                beats[n].segments = wseg[i];
                beats[n].last = 1'b0;
                n++;
            end
        end
        if (n > 0)
            beats[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_slots.push_back(beats[i]);
    endfunction

    // Random value, weighted towards what fits the current radix
    function automatic nfmt_pkg::nfmt_in_t random_operand();
        logic [63:0] b, span;
        logic [47:0] raw;
        logic        neg;
        int          mode;
        nfmt_pkg::nfmt_in_t item;

        b = clamp_radix(radix_reg);
        neg = 1'($urandom_range(0, 1));
        span = radix_pow(b, neg ? 3 : 4);
        mode = $urandom_range(0, 9);
        raw = 48'({$urandom, $urandom});
        if (mode <= 5)
            raw = (48'($urandom_range(0, 32'(span)) >> $urandom_range(0, 12)) << FRAC_BITS)
                  | 48'($urandom_range(0, 65535));
        else if (mode == 6)
            raw = 48'($urandom_range(0, 65535));
        else if (mode == 7)
            raw = (48'(span - 64'($urandom_range(0, 1))) << FRAC_BITS)
                  | 48'($urandom_range(0, 65535));
        if (mode <= 7 && neg)
            raw = ~raw + 48'd1;
        item.value = raw;
        item.fraction_digits = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                            : 3'($urandom_range(0, 4));
        return item;
    endfunction

    // Offer one value; called at a falling edge, returns at a falling edge
    task automatic offer_value(input nfmt_pkg::nfmt_in_t item, input logic typed,
                               input logic [39:0] segs, input logic [14:0] poss);
        nfmt_pkg::nfmt_out_t beat;
        start <= 1'b1;
        operand <= item;
        do
            @(posedge clk);
        while (busy);
        if (typed)
        begin
            for (int j = 0; j < 5; j++)
            begin
                beat.digit_position = poss[14 - 3*j -: 3];
                beat.segments = segs[39 - 8*j -: 8];
                beat.last = (j == 4);
                pending_slots.push_back(beat);
            end
        end
        else
            format_value(item);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            // end of burst: idle for a while with noise on the operand
            start <= 1'b0;
            operand <= nfmt_pkg::nfmt_in_t'({$urandom, $urandom});
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 4))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Stop offering and let every expected beat arrive; ends at a falling edge
    task automatic drain_results();
        start <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_radix(input logic [4:0] r);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        radix_reg = r;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Check each strobed beat against the oldest expectation
    always @(posedge clk)
    begin
        nfmt_pkg::nfmt_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_slots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: pos %0d seg %02h last %0b",
                             slot.digit_position, slot.segments, slot.last);
            end
            else
            begin
                want = pending_slots.pop_front();
                if (slot.digit_position !== want.digit_position ||
                    slot.segments !== want.segments || slot.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch: expected pos %0d seg %02h last %0b, ",
                                  "got pos %0d seg %02h last %0b"},
                                 want.digit_position, want.segments, want.last,
                                 slot.digit_position, slot.segments, slot.last);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        nfmt_pkg::nfmt_in_t item;
        logic [4:0] r;

        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        radix_reg = nfmt_pkg::BASE_RESET;
        @(negedge clk);
        burst_left = $urandom_range(1, 8);

        // directed values at the reset radix
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            item.value = stim_tab[i].value;
            item.fraction_digits = stim_tab[i].digits;
            offer_value(item, stim_tab[i].typed, stim_tab[i].segs, stim_tab[i].poss);
        end

        // random phases, each under its own radix
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            r = (p < 10) ? RADIX_PLAN[p] : 5'($urandom_range(0, 31));
            write_radix(r);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                offer_value(random_operand(), 1'b0, 40'h0, 15'h0);
        end

        drain_results();
        if (mismatches == 0)
            $display("tb_number_to_seven_segment_formatter_core: PASS");
        else
            $display("tb_number_to_seven_segment_formatter_core: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/nfmt_pkg.sv
rtl/nfmt_front.sv
rtl/nfmt_queue.sv
rtl/nfmt_back.sv
rtl/number_to_seven_segment_formatter_core.sv
tb/tb_number_to_seven_segment_formatter_core.sv
